/* rtl/can_bit_timing_calc_top_assert.svh */
// Assertion macros for the CAN bit timing calculator top level.
`ifndef CAN_BIT_TIMING_CALC_TOP_ASSERT_SVH
`define CAN_BIT_TIMING_CALC_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cbt_pkg.sv */
// Types, constants and helper functions shared by the CAN bit timing calculator.
`default_nettype none

package cbt_pkg;

  localparam int CLK_W  = 28;
  localparam int RATE_W = 24;
  localparam int DIV_W  = 28;
  localparam int CNT_W  = $clog2(DIV_W);
  localparam int SUM_W  = 5;

  localparam logic [CLK_W-1:0]  CLK_RATE_RESET = 28'd8000000;
  localparam logic [RATE_W-1:0] RATE_MIN       = 24'd1000;
  localparam logic [RATE_W-1:0] RATE_FAST      = 24'd1000000;
  localparam logic [SUM_W-1:0]  SUM_FAST_START = 5'd9;
  localparam logic [SUM_W-1:0]  SUM_SLOW_START = 5'd16;
  localparam logic [SUM_W-1:0]  SUM_LAST       = 5'd2;
  localparam logic [15:0]       SP_SCALE       = 16'd1000;
  localparam logic [15:0]       SP_LIMIT_NEXT  = 16'd901;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PBS_WAIT,
    ST_MOD_ISSUE,
    ST_MOD_WAIT,
    ST_CHK_ISSUE,
    ST_CHK_WAIT,
    ST_RESULT
  } cbt_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

  // Segment 1 for a given segment sum, at the nearest 87.5% sample point,
  // truncated instead when that sample point lies above 900 permille.
  function automatic logic [SUM_W-1:0] cbt_seg1(input logic [SUM_W-1:0] sum);
    logic [7:0]       sum7;
    logic [SUM_W-1:0] near;
    logic [SUM_W-1:0] trunc;
    logic [15:0]      lhs;
    logic [15:0]      rhs;
    sum7  = 8'(sum) * 8'd7;
    near  = SUM_W'((sum7 + 8'd3) >> 3);
    trunc = SUM_W'((sum7 - 8'd1) >> 3);
    lhs   = SP_SCALE * (16'(near) + 16'd1);
    rhs   = SP_LIMIT_NEXT * (16'(sum) + 16'd1);
    return (lhs >= rhs) ? trunc : near;
  endfunction

endpackage

`default_nettype wire

/* rtl/cbt_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all divisions.
`default_nettype none

module cbt_div import cbt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_W+1:0] diff;

  always_comb begin
    diff     = {1'b0, rem_r, quo_r[DIV_W-1]} - {2'b00, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], ~diff[DIV_W+1]};
      rem_nxt = diff[DIV_W+1] ? {rem_r[DIV_W-2:0], quo_r[DIV_W-1]} : diff[DIV_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

/* rtl/cbt_seq.sv */
// Sequencer that drives the shared divider through the bit timing search.
`default_nettype none

module cbt_seq import cbt_pkg::*; #(
  parameter int PRESCALER_MAX = 1024,
  parameter int SEG1_MAX      = 16,
  parameter int SEG2_MAX      = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CLK_W-1:0]  cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [RATE_W-1:0] in_target_bitrate,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_ok,
  output logic [10:0]            out_prescaler,
  output logic [4:0]             out_seg1,
  output logic [3:0]             out_seg2,
  output logic                   out_sjw,
  output div_req_t               div_req,
  input  wire div_rsp_t          div_rsp
);

  cbt_state_t        state_r, state_nxt;
  logic [CLK_W-1:0]  clk_rate_r, clk_rate_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [DIV_W-1:0]  pbs_r, pbs_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [10:0]       pre_r, pre_nxt;
  logic [SUM_W-1:0]  b1_r, b1_nxt;
  logic [SUM_W-1:0]  b2_r, b2_nxt;
  logic              ok_r, ok_nxt;
  logic              ov_r, ov_nxt;
  logic              oo_r, oo_nxt;
  logic [10:0]       opre_r, opre_nxt;
  logic [4:0]        os1_r, os1_nxt;
  logic [3:0]        os2_r, os2_nxt;
  logic              osjw_r, osjw_nxt;
  logic [SUM_W-1:0]  b1_cand;
  logic [SUM_W-1:0]  b2_cand;
  logic              seg_bad;
  logic              pre_bad;

  always_comb begin
    b1_cand = cbt_seg1(sum_r);
    b2_cand = sum_r - b1_cand;
    seg_bad = (b1_cand == '0) || (32'(b1_cand) > 32'(SEG1_MAX)) ||
              (b2_cand == '0) || (32'(b2_cand) > 32'(SEG2_MAX));
    pre_bad = (div_rsp.quotient == '0) ||
              (32'(div_rsp.quotient) > 32'(PRESCALER_MAX));
  end

  always_comb begin
    state_nxt        = state_r;
    clk_rate_nxt     = cfg_we ? cfg_wdata : clk_rate_r;
    rate_nxt         = rate_r;
    pbs_nxt          = pbs_r;
    sum_nxt          = sum_r;
    pre_nxt          = pre_r;
    b1_nxt           = b1_r;
    b2_nxt           = b2_r;
    ok_nxt           = ok_r;
    ov_nxt           = ov_r && out_stall;
    oo_nxt           = oo_r;
    opre_nxt         = opre_r;
    os1_nxt          = os1_r;
    os2_nxt          = os2_r;
    osjw_nxt         = osjw_r;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(clk_rate_r);
    div_req.divisor  = DIV_W'(rate_r);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rate_nxt = in_target_bitrate;
          ok_nxt   = 1'b0;
          if (in_target_bitrate < RATE_MIN) begin
            state_nxt = ST_RESULT;
          end else begin
            div_req.start   = 1'b1;
            div_req.divisor = DIV_W'(in_target_bitrate);
            state_nxt       = ST_PBS_WAIT;
          end
        end
      end
      ST_PBS_WAIT: begin
        if (div_rsp.done) begin
          pbs_nxt   = div_rsp.quotient;
          sum_nxt   = (rate_r >= RATE_FAST) ? SUM_FAST_START : SUM_SLOW_START;
          state_nxt = ST_MOD_ISSUE;
        end
      end
      ST_MOD_ISSUE: begin
        div_req.start    = 1'b1;
        div_req.dividend = pbs_r;
        div_req.divisor  = DIV_W'(sum_r) + DIV_W'(1);
        state_nxt        = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.remainder == '0) begin
            pre_nxt = div_rsp.quotient[10:0];
            b1_nxt  = b1_cand;
            b2_nxt  = b2_cand;
            if (pre_bad || seg_bad) begin
              state_nxt = ST_RESULT;
            end else begin
              state_nxt = ST_CHK_ISSUE;
            end
          end else if (sum_r <= SUM_LAST) begin
            state_nxt = ST_RESULT;
          end else begin
            sum_nxt   = sum_r - 1'b1;
            state_nxt = ST_MOD_ISSUE;
          end
        end
      end
      ST_CHK_ISSUE: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(clk_rate_r);
        div_req.divisor  = pbs_r;
        state_nxt        = ST_CHK_WAIT;
      end
      ST_CHK_WAIT: begin
        if (div_rsp.done) begin
          ok_nxt    = (div_rsp.quotient == DIV_W'(rate_r));
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          oo_nxt    = ok_r;
          opre_nxt  = ok_r ? pre_r : '0;
          os1_nxt   = ok_r ? 5'(b1_r) : '0;
          os2_nxt   = ok_r ? 4'(b2_r) : '0;
          osjw_nxt  = ok_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      clk_rate_r <= CLK_RATE_RESET;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clk_rate_r <= clk_rate_nxt;
      ov_r       <= ov_nxt;
    end
    rate_r <= rate_nxt;
    pbs_r  <= pbs_nxt;
    sum_r  <= sum_nxt;
    pre_r  <= pre_nxt;
    b1_r   <= b1_nxt;
    b2_r   <= b2_nxt;
    ok_r   <= ok_nxt;
    oo_r   <= oo_nxt;
    opre_r <= opre_nxt;
    os1_r  <= os1_nxt;
    os2_r  <= os2_nxt;
    osjw_r <= osjw_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = ov_r;
  assign out_ok        = oo_r;
  assign out_prescaler = opre_r;
  assign out_seg1      = os1_r;
  assign out_seg2      = os2_r;
  assign out_sjw       = osjw_r;

endmodule

`default_nettype wire

/* rtl/can_bit_timing_calc_top.sv */
// Top level of the CAN bit timing calculator.
//
//   Channel  Direction  Handshake             Payload
//   cfg      in         cfg_we                cfg_wdata (clock rate in Hz)
//   in       in         in_valid / in_stall   in_target_bitrate
//   out      out        out_valid / out_stall out_ok, out_prescaler, out_seg1,
//                                             out_seg2, out_sjw
//
// A request of 1000 bit/s or more divides clock rate by bit rate, then makes one division
// per tried segment sum (up to 15) and, if a sum fits, one for the final rate check.
// All three divisions run on one restoring divider that yields one bit per cycle.
// Reset sets the clock rate to 8 MHz and empties the output register.
// The input is stalled while a request is being worked on; a finished result
// waits in the output register while the next request is accepted.
`default_nettype none
`include "can_bit_timing_calc_top_assert.svh"

module can_bit_timing_calc_top import cbt_pkg::*; #(
  parameter int PRESCALER_MAX = 1024,
  parameter int SEG1_MAX      = 16,
  parameter int SEG2_MAX      = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CLK_W-1:0]  cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [RATE_W-1:0] in_target_bitrate,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_ok,
  output logic [10:0]            out_prescaler,
  output logic [4:0]             out_seg1,
  output logic [3:0]             out_seg2,
  output logic                   out_sjw
);

  div_req_t div_req;
  div_rsp_t div_rsp;

  cbt_seq #(
    .PRESCALER_MAX (PRESCALER_MAX),
    .SEG1_MAX      (SEG1_MAX),
    .SEG2_MAX      (SEG2_MAX)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_target_bitrate (in_target_bitrate),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ok            (out_ok),
    .out_prescaler     (out_prescaler),
    .out_seg1          (out_seg1),
    .out_seg2          (out_seg2),
    .out_sjw           (out_sjw),
    .div_req           (div_req),
    .div_rsp           (div_rsp)
  );

  cbt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  `CBT_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && !out_ok, (out_prescaler == '0) && (out_seg1 == '0) && (out_seg2 == '0) && !out_sjw, "failed result with nonzero fields")
  `CBT_ASSERT_NOW(a_ok_fields, clk, rst_n, out_valid && out_ok, out_sjw && (out_seg1 != '0) && (out_seg2 != '0), "good result with empty segment")
  `CBT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input not stalled after an accepted request")

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the CAN bit timing calculator with a built-in timing predictor.
`timescale 1ns / 100ps

module testbench;
  import cbt_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [10:0] prescaler;
    logic [4:0]  seg1;
    logic [3:0]  seg2;
    logic        sjw;
  } timing_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic              typed;
    timing_t           want;
  } probe_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  localparam int unsigned PRESCALER_LIMIT = 1024;
  localparam int unsigned SEG1_LIMIT      = 16;
  localparam int unsigned SEG2_LIMIT      = 8;
  localparam int unsigned MIN_RATE        = 1000;
  localparam int unsigned FAST_RATE       = 1000000;
  localparam int unsigned FAST_QUANTA     = 10;
  localparam int unsigned SLOW_QUANTA     = 17;
  localparam int unsigned SAMPLE_LIMIT    = 900;
  localparam int unsigned CLOCK_MAX       = 200000000;
  localparam int          PHASES          = 12;
  localparam int          PHASE_REQUESTS  = 60;
  localparam int          LONG_HOLD       = 400;
  localparam int          DRAIN_CYCLES    = 600;
  localparam int          CYCLE_LIMIT     = 2000000;

  localparam timing_t NO_TIMING = '0;

  localparam probe_t PROBES [21] = '{
    '{24'd0,        1'b1, NO_TIMING},
    '{24'd999,      1'b1, NO_TIMING},
    '{24'd1000,     1'b1, '{1'b1, 11'd500, 5'd13, 4'd2, 1'b1}},
    '{24'd1001,     1'b0, NO_TIMING},
    '{24'd10000,    1'b0, NO_TIMING},
    '{24'd33333,    1'b0, NO_TIMING},
    '{24'd100000,   1'b1, '{1'b1, 11'd5, 5'd13, 4'd2, 1'b1}},
    '{24'd125000,   1'b1, '{1'b1, 11'd4, 5'd13, 4'd2, 1'b1}},
    '{24'd250000,   1'b1, '{1'b1, 11'd2, 5'd13, 4'd2, 1'b1}},
    '{24'd500000,   1'b1, '{1'b1, 11'd1, 5'd13, 4'd2, 1'b1}},
    '{24'd666666,   1'b1, '{1'b1, 11'd1, 5'd9, 4'd2, 1'b1}},
    '{24'd999999,   1'b1, NO_TIMING},
    '{24'd1000000,  1'b1, '{1'b1, 11'd1, 5'd6, 4'd1, 1'b1}},
    '{24'd2000000,  1'b1, '{1'b1, 11'd1, 5'd2, 4'd1, 1'b1}},
    '{24'd2666666,  1'b0, NO_TIMING},
    '{24'd8000000,  1'b1, NO_TIMING},
    '{24'hFFFFFF,   1'b1, NO_TIMING},
    '{24'h800000,   1'b0, NO_TIMING},
    '{24'h7FFFFF,   1'b0, NO_TIMING},
    '{24'h555555,   1'b0, NO_TIMING},
    '{24'hAAAAAA,   1'b0, NO_TIMING}
  };

  localparam logic [CLK_W-1:0] CLOCK_PLAN [10] = '{
    28'd0, 28'd1, 28'd200000000, 28'd16000000, 28'd24000000,
    28'd36000000, 28'd80000000, 28'd40000000, 28'd20000000, 28'd48000000
  };

  localparam int unsigned BUS_RATES [10] = '{
    10000, 20000, 50000, 83333, 100000, 125000, 250000, 500000, 800000, 1000000
  };

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CLK_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [RATE_W-1:0] in_target_bitrate = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_ok;
  logic [10:0]       out_prescaler;
  logic [4:0]        out_seg1;
  logic [3:0]        out_seg2;
  logic              out_sjw;

  timing_t          timing_q [$];
  timing_t          got_timing;
  timing_t          want_timing;
  logic [CLK_W-1:0] clock_hz_model = CLK_RATE_RESET;
  idle_mode_t       idle_mode = IDLE_NONE;
  int               mismatches = 0;
  int               requests = 0;
  int               solved = 0;
  int               rejected = 0;
  int               settings_used = 1;
  int               hold_asks = 0;
  int               hold_given = 0;
  int               hold_left = 0;
  int               cycles = 0;

  can_bit_timing_calc_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_target_bitrate(in_target_bitrate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_prescaler    (out_prescaler),
    .out_seg1         (out_seg1),
    .out_seg2         (out_seg2),
    .out_sjw          (out_sjw)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic timing_t predict_timing(input logic [CLK_W-1:0] clk_hz,
                                             input logic [RATE_W-1:0] rate);
    timing_t     t;
    int unsigned quanta_cap;
    int unsigned per_bit;
    int unsigned sum;
    int unsigned presc;
    int unsigned tseg1;
    int unsigned tseg2;
    int unsigned permille;
    t = NO_TIMING;
    if (rate < MIN_RATE) return t;
    quanta_cap = (rate >= FAST_RATE) ? FAST_QUANTA : SLOW_QUANTA;
    per_bit = clk_hz / rate;
    sum = quanta_cap - 1;
    while ((per_bit % (sum + 1)) != 0) begin
      if (sum <= 2) return t;
      sum--;
    end
    presc = per_bit / (sum + 1);
    if (presc < 1 || presc > PRESCALER_LIMIT) return t;
    tseg1 = (7 * sum + 3) / 8;
    permille = 1000 * (tseg1 + 1) / (sum + 1);
    if (permille > SAMPLE_LIMIT) begin
      tseg1 = (7 * sum - 1) / 8;
    end
    tseg2 = sum - tseg1;
    if (tseg1 < 1 || tseg1 > SEG1_LIMIT || tseg2 < 1 || tseg2 > SEG2_LIMIT) return t;
    if (clk_hz / (presc * (1 + tseg1 + tseg2)) != rate) return t;
    t.ok        = 1'b1;
    t.prescaler = 11'(presc);
    t.seg1      = 5'(tseg1);
    t.seg2      = 4'(tseg2);
    t.sjw       = 1'b1;
    return t;
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate(input logic [CLK_W-1:0] clk_hz);
    int unsigned roll;
    int unsigned quanta;
    int unsigned presc;
    int unsigned rate;
    roll = $urandom_range(99);
    if (roll < 55) begin
      quanta = $urandom_range(17, 3);
      presc = ($urandom_range(3) == 0) ? $urandom_range(1100, 1) : $urandom_range(16, 1);
      rate = clk_hz / (presc * quanta);
      if ($urandom_range(4) == 0) rate = rate + $urandom_range(2) - 1;
    end else if (roll < 75) begin
      rate = BUS_RATES[$urandom_range(9)];
    end else if (roll < 90) begin
      rate = $urandom_range(24'hFFFFFF);
    end else begin
      rate = $urandom_range(2000);
    end
    return rate[RATE_W-1:0];
  endfunction

  function automatic bit sender_pauses();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 45;
      IDLE_BOTH:   return $urandom_range(99) < 6;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_pauses();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 45;
      IDLE_BOTH:     return $urandom_range(99) < 6;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic offer_rate(input logic [RATE_W-1:0] rate, input timing_t want);
    while (sender_pauses()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_bitrate <= rate;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    timing_q.push_back(want);
    requests++;
  endtask

  task automatic wait_all_answered();
    in_valid <= 1'b0;
    while (timing_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_clock(input logic [CLK_W-1:0] clk_hz);
    cfg_we <= 1'b1;
    cfg_wdata <= clk_hz;
    @(posedge clk);
    cfg_we <= 1'b0;
    clock_hz_model = clk_hz;
    settings_used++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               timing_q.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_timing = '{out_ok, out_prescaler, out_seg1, out_seg2, out_sjw};
      if (timing_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result with no request pending: ok=%0d pre=%0d seg1=%0d seg2=%0d sjw=%0d",
                   got_timing.ok, got_timing.prescaler, got_timing.seg1,
                   got_timing.seg2, got_timing.sjw);
        end
      end else begin
        want_timing = timing_q.pop_front();
        if (got_timing.ok) solved++;
        else rejected++;
        if (got_timing !== want_timing) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t: expected ok=%0d pre=%0d seg1=%0d seg2=%0d sjw=%0d, got ok=%0d pre=%0d seg1=%0d seg2=%0d sjw=%0d",
                     $realtime, want_timing.ok, want_timing.prescaler, want_timing.seg1,
                     want_timing.seg2, want_timing.sjw, got_timing.ok,
                     got_timing.prescaler, got_timing.seg1, got_timing.seg2,
                     got_timing.sjw);
          end
        end
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_asks != hold_given) begin
      hold_given++;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_pauses();
    end
  end

  initial begin
    int               phase;
    int               k;
    logic [CLK_W-1:0] clk_hz;
    logic [RATE_W-1:0] rate;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed probes run against the clock rate left by reset.
    for (k = 0; k < $size(PROBES); k++) begin
      offer_rate(PROBES[k].rate, PROBES[k].typed ? PROBES[k].want
                                                  : predict_timing(clock_hz_model,
                                                                   PROBES[k].rate));
    end
    wait_all_answered();

    for (phase = 0; phase < PHASES; phase++) begin
      clk_hz = (phase < $size(CLOCK_PLAN)) ? CLOCK_PLAN[phase]
                                             : CLK_W'($urandom_range(CLOCK_MAX, 1));
      write_clock(clk_hz);
      idle_mode = idle_mode_t'(phase % 4);
      if (phase == 1 || phase == 6) hold_asks++;
      for (k = 0; k < PHASE_REQUESTS; k++) begin
        rate = pick_rate(clock_hz_model);
        offer_rate(rate, predict_timing(clock_hz_model, rate));
        if (phase % 2 == 1 && k == PHASE_REQUESTS / 2) wait_all_answered();
      end
      wait_all_answered();
    end

    idle_mode = IDLE_NONE;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d requests under %0d clock settings: %0d timings found, %0d rejected.",
             requests, settings_used, solved, rejected);
    $display("Output held off for long stretches %0d times while requests kept coming.",
             hold_given);
    if (mismatches == 0 && timing_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/cbt_pkg.sv
rtl/cbt_div.sv
rtl/cbt_seq.sv
rtl/can_bit_timing_calc_top.sv
dv/testbench.sv
